// ----- design/voxel_line_of_sight_macros.svh -----
// assertion macros shared by the voxel line-of-sight design
`ifndef VOXEL_LINE_OF_SIGHT_MACROS_SVH
`define VOXEL_LINE_OF_SIGHT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define VLOS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voxel_line_of_sight: same-cycle check failed");
// next-cycle implication check
`define VLOS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voxel_line_of_sight: next-cycle check failed");
`else
`define VLOS_ASSERT_IMP(label, clk, rst, ante, cons)
`define VLOS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/vlos_pkg.sv -----
// shared types and constants of the voxel line-of-sight design
package vlos_pkg;

   // coordinate field widths
   localparam int X_W = 6;
   localparam int Y_W = 6;
   localparam int Z_W = 7;

   // width that holds any grid dimension (up to 2047)
   localparam int LIM_W = 11;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic [Z_W-1:0] z;
   } coord_type;

   typedef struct packed {
      command_type command;
      coord_type   src;
      coord_type   dst;
      logic        opaque;
   } item_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

// ----- design/voxel_line_of_sight.sv -----
// top level of the voxel grid line-of-sight engine
//
// The block holds a GRID_X x GRID_Y x GRID_Z grid of one-bit cells (1 opaque,
// 0 transparent) in a single-port-write, registered-read ram. A request word
// either writes one cell (no response) or asks whether the target cell can be
// seen from the source cell (one response word carrying visible). After reset
// the grid is swept to transparent, one cell per cycle; req_stall stays high
// for that whole sweep. A front part computes linear cell addresses in two
// pipeline stages and feeds a four-word queue; a back part sequences the work
// against the grid ram. A write is done from the idle state as it is popped.
// A query runs the direct walk and then up to three retries, each retry
// preceded by a probe of the pulled-in target cell: ST_PROBE, then
// ST_PROBE_CHK when source and target differ on that axis and the cell
// lies in the grid. A walk costs one ram read per step, pipelined so that
// each read overlaps the opacity check of the step before, and reads as
// many cells as the largest per-axis distance. The worst-case query holds
// the back part through its pop, four walks, three probes and the response
// load, bounded by the one grid read per step through the single ram read
// port. Responses leave from an output register, so the front keeps taking
// request words while a response waits on rsp_stall, until the queue backs
// up behind a query held in ST_DONE.
`include "voxel_line_of_sight_macros.svh"

module voxel_line_of_sight #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [vlos_pkg::X_W-1:0] req_src_x,
   input  logic [vlos_pkg::Y_W-1:0] req_src_y,
   input  logic [vlos_pkg::Z_W-1:0] req_src_z,
   input  logic [vlos_pkg::X_W-1:0] req_dst_x,
   input  logic [vlos_pkg::Y_W-1:0] req_dst_y,
   input  logic [vlos_pkg::Z_W-1:0] req_dst_z,
   input  logic                     req_cell_is_opaque,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_visible
);

   import vlos_pkg::*;

   localparam int DEPTH       = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_WIDTH     = $bits(item_type) + 2 * ADDR_W;

   // front to queue
   logic              push_valid;
   item_type          push_item;
   logic [ADDR_W-1:0] push_src_addr;
   logic [ADDR_W-1:0] push_dst_addr;
   logic              push_full;

   // queue to back
   logic               q_pop;
   logic               q_pop_valid;
   logic [Q_WIDTH-1:0] q_pop_data;
   item_type           q_item;
   logic [ADDR_W-1:0]  q_src_addr;
   logic [ADDR_W-1:0]  q_dst_addr;

   // grid ram
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic              ram_rd_data;

   back_status_type back_status;

   // address calculation, stalled during the clear sweep
   vlos_front #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .hold               (back_status.clearing),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_src_x          (req_src_x),
      .req_src_y          (req_src_y),
      .req_src_z          (req_src_z),
      .req_dst_x          (req_dst_x),
      .req_dst_y          (req_dst_y),
      .req_dst_z          (req_dst_z),
      .req_cell_is_opaque (req_cell_is_opaque),
      .push_valid         (push_valid),
      .push_item          (push_item),
      .push_src_addr      (push_src_addr),
      .push_dst_addr      (push_dst_addr),
      .push_full          (push_full)
   );

   // decoupling queue, words kept in arrival order so writes and queries stay ordered
   vlos_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_item, push_src_addr, push_dst_addr}),
      .full       (push_full),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data)
   );

   assign {q_item, q_src_addr, q_dst_addr} = q_pop_data;

   // clear sweep, cell writes, walks and retries
   vlos_back #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_pop_valid),
      .q_item      (q_item),
      .q_src_addr  (q_src_addr),
      .q_dst_addr  (q_dst_addr),
      .q_pop       (q_pop),
      .wr_en       (ram_wr_en),
      .wr_addr     (ram_wr_addr),
      .wr_data     (ram_wr_data),
      .rd_addr     (ram_rd_addr),
      .rd_data     (ram_rd_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_visible (rsp_visible),
      .status      (back_status)
   );

   // one bit per grid cell
   vlos_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // nothing enters and no response is pending while the grid is being cleared
   `VLOS_ASSERT_IMP(a_clear_blocks, clock, reset, back_status.clearing, req_stall && !rsp_valid)
   // a response only follows back-part work
   `VLOS_ASSERT_IMP(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(back_status.busy))
   // the clear sweep ends with an empty queue
   `VLOS_ASSERT_IMP(a_clear_ends_empty, clock, reset, $fell(back_status.clearing), !q_pop_valid)
   // a popped query starts the walk sequencer
   `VLOS_ASSERT_NXT(a_query_starts, clock, reset, q_pop && q_pop_valid && q_item.command == CMD_QUERY, back_status.busy)

endmodule

// ----- design/vlos_ram.sv -----
// generic simple dual-port ram with registered read
module vlos_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/vlos_queue.sv -----
// small show-ahead fifo between the front and back parts
module vlos_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = data_ff[rd_ptr_ff];
   assign push_ok   = push_valid && !full;
   assign pop_ok    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/vlos_front.sv -----
// front part: takes request words and works out their grid addresses
module vlos_front #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 128,
   localparam int ADDR_W = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      hold,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [vlos_pkg::X_W-1:0]  req_src_x,
   input  logic [vlos_pkg::Y_W-1:0]  req_src_y,
   input  logic [vlos_pkg::Z_W-1:0]  req_src_z,
   input  logic [vlos_pkg::X_W-1:0]  req_dst_x,
   input  logic [vlos_pkg::Y_W-1:0]  req_dst_y,
   input  logic [vlos_pkg::Z_W-1:0]  req_dst_z,
   input  logic                      req_cell_is_opaque,
   output logic                      push_valid,
   output vlos_pkg::item_type        push_item,
   output logic [ADDR_W-1:0]         push_src_addr,
   output logic [ADDR_W-1:0]         push_dst_addr,
   input  logic                      push_full
);

   import vlos_pkg::*;

   localparam logic [ADDR_W-1:0] Y_MUL = ADDR_W'(GRID_Y);
   localparam logic [ADDR_W-1:0] Z_MUL = ADDR_W'(GRID_Z);

   logic              s1_valid_ff, s1_valid_in;
   item_type          s1_item_ff, s1_item_in;
   logic [ADDR_W-1:0] s1_sxy_ff, s1_sxy_in;
   logic [ADDR_W-1:0] s1_dxy_ff, s1_dxy_in;
   logic              s2_valid_ff, s2_valid_in;
   item_type          s2_item_ff;
   logic [ADDR_W-1:0] s2_src_addr_ff, s2_src_addr_in;
   logic [ADDR_W-1:0] s2_dst_addr_ff, s2_dst_addr_in;
   logic              accept, s1_move, s1_free, s2_free, s2_push;

   assign s2_push   = s2_valid_ff && !push_full;
   assign s2_free   = !s2_valid_ff || !push_full;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = hold || !s1_free;
   assign accept    = req_valid && !req_stall;

   // stage 1: x*GRID_Y + y
   always_comb begin
      s1_item_in.command = command_type'(req_command);
      s1_item_in.src     = '{x: req_src_x, y: req_src_y, z: req_src_z};
      s1_item_in.dst     = '{x: req_dst_x, y: req_dst_y, z: req_dst_z};
      s1_item_in.opaque  = req_cell_is_opaque;
      s1_sxy_in = ADDR_W'(req_src_x) * Y_MUL + ADDR_W'(req_src_y);
      s1_dxy_in = ADDR_W'(req_dst_x) * Y_MUL + ADDR_W'(req_dst_y);
   end

   // stage 2: (x*GRID_Y + y)*GRID_Z + z
   assign s2_src_addr_in = s1_sxy_ff * Z_MUL + ADDR_W'(s1_item_ff.src.z);
   assign s2_dst_addr_in = s1_dxy_ff * Z_MUL + ADDR_W'(s1_item_ff.dst.z);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_push) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (accept) begin
         s1_item_ff <= s1_item_in;
         s1_sxy_ff  <= s1_sxy_in;
         s1_dxy_ff  <= s1_dxy_in;
      end
      if (s1_move) begin
         s2_item_ff     <= s1_item_ff;
         s2_src_addr_ff <= s2_src_addr_in;
         s2_dst_addr_ff <= s2_dst_addr_in;
      end
   end

   assign push_valid    = s2_valid_ff;
   assign push_item     = s2_item_ff;
   assign push_src_addr = s2_src_addr_ff;
   assign push_dst_addr = s2_dst_addr_ff;

endmodule

// ----- design/vlos_back.sv -----
// back part: grid clear, cell writes and the line-of-sight walk sequencer
module vlos_back #(
   parameter int GRID_X = 64,
   parameter int GRID_Y = 64,
   parameter int GRID_Z = 128,
   localparam int ADDR_W = $clog2(GRID_X * GRID_Y * GRID_Z)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  vlos_pkg::item_type        q_item,
   input  logic [ADDR_W-1:0]         q_src_addr,
   input  logic [ADDR_W-1:0]         q_dst_addr,
   output logic                      q_pop,
   output logic                      wr_en,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic                      wr_data,
   output logic [ADDR_W-1:0]         rd_addr,
   input  logic                      rd_data,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic                      rsp_visible,
   output vlos_pkg::back_status_type status
);

   import vlos_pkg::*;

   localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] X_STEP    = ADDR_W'(GRID_Y * GRID_Z);
   localparam logic [ADDR_W-1:0] Y_STEP    = ADDR_W'(GRID_Z);
   localparam logic [ADDR_W-1:0] Z_STEP    = ADDR_W'(1);
   localparam logic [LIM_W-1:0]  LIM_X     = LIM_W'(GRID_X);
   localparam logic [LIM_W-1:0]  LIM_Y     = LIM_W'(GRID_Y);
   localparam logic [LIM_W-1:0]  LIM_Z     = LIM_W'(GRID_Z);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_PROBE,
      ST_PROBE_CHK,
      ST_DONE
   } state_type;

   // direct walk, then retries with the target pulled in along x, y, z
   typedef enum logic [1:0] {
      ATT_DIRECT,
      ATT_X,
      ATT_Y,
      ATT_Z
   } attempt_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_ff, clear_in;
   item_type          item_ff, item_in;
   logic [ADDR_W-1:0] src_addr_ff, src_addr_in;
   logic [ADDR_W-1:0] dst_addr_ff, dst_addr_in;
   coord_type         pos_ff, pos_in;
   coord_type         tgt_ff, tgt_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   attempt_type       attempt_ff, attempt_in;
   logic              pend_ff, pend_in;
   logic              pend_bad_ff, pend_bad_in;
   logic              result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_visible_ff, rsp_visible_in;

   coord_type         probe_c;
   logic [ADDR_W-1:0] probe_addr;
   logic              probe_differ;
   logic              prev_opaque, at_tgt, give_up, out_free;
   attempt_type       next_attempt;

   function automatic logic in_grid(coord_type c);
      return (LIM_W'(c.x) < LIM_X) && (LIM_W'(c.y) < LIM_Y) && (LIM_W'(c.z) < LIM_Z);
   endfunction

   function automatic coord_type step_pos(coord_type p, coord_type t);
      coord_type n;
      n = p;
      if (t.x > p.x) n.x = p.x + X_W'(1);
      else if (t.x < p.x) n.x = p.x - X_W'(1);
      if (t.y > p.y) n.y = p.y + Y_W'(1);
      else if (t.y < p.y) n.y = p.y - Y_W'(1);
      if (t.z > p.z) n.z = p.z + Z_W'(1);
      else if (t.z < p.z) n.z = p.z - Z_W'(1);
      return n;
   endfunction

   function automatic logic [ADDR_W-1:0] step_delta(coord_type p, coord_type t);
      logic [ADDR_W-1:0] d;
      d = '0;
      if (t.x > p.x) d = d + X_STEP;
      else if (t.x < p.x) d = d - X_STEP;
      if (t.y > p.y) d = d + Y_STEP;
      else if (t.y < p.y) d = d - Y_STEP;
      if (t.z > p.z) d = d + Z_STEP;
      else if (t.z < p.z) d = d - Z_STEP;
      return d;
   endfunction

   // target cell pulled one step toward the source along the retry axis
   always_comb begin
      probe_c      = item_ff.dst;
      probe_addr   = dst_addr_ff;
      probe_differ = 1'b0;
      case (attempt_ff)
         ATT_X: begin
            probe_differ = (item_ff.src.x != item_ff.dst.x);
            if (item_ff.src.x > item_ff.dst.x) begin
               probe_c.x  = item_ff.dst.x + X_W'(1);
               probe_addr = dst_addr_ff + X_STEP;
            end else begin
               probe_c.x  = item_ff.dst.x - X_W'(1);
               probe_addr = dst_addr_ff - X_STEP;
            end
         end
         ATT_Y: begin
            probe_differ = (item_ff.src.y != item_ff.dst.y);
            if (item_ff.src.y > item_ff.dst.y) begin
               probe_c.y  = item_ff.dst.y + Y_W'(1);
               probe_addr = dst_addr_ff + Y_STEP;
            end else begin
               probe_c.y  = item_ff.dst.y - Y_W'(1);
               probe_addr = dst_addr_ff - Y_STEP;
            end
         end
         ATT_Z: begin
            probe_differ = (item_ff.src.z != item_ff.dst.z);
            if (item_ff.src.z > item_ff.dst.z) begin
               probe_c.z  = item_ff.dst.z + Z_W'(1);
               probe_addr = dst_addr_ff + Z_STEP;
            end else begin
               probe_c.z  = item_ff.dst.z - Z_W'(1);
               probe_addr = dst_addr_ff - Z_STEP;
            end
         end
         default: begin
            probe_differ = 1'b0;
         end
      endcase
   end

   assign prev_opaque  = pend_ff && (pend_bad_ff || rd_data);
   assign at_tgt       = (pos_ff == tgt_ff);
   assign give_up      = (attempt_ff == ATT_Z);
   assign next_attempt = attempt_type'(attempt_ff + 2'd1);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      clear_in       = clear_ff;
      item_in        = item_ff;
      src_addr_in    = src_addr_ff;
      dst_addr_in    = dst_addr_ff;
      pos_in         = pos_ff;
      tgt_in         = tgt_ff;
      addr_in        = addr_ff;
      attempt_in     = attempt_ff;
      pend_in        = 1'b0;
      pend_bad_in    = pend_bad_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_visible_in = rsp_visible_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = clear_ff;
      wr_data        = 1'b0;
      rd_addr        = addr_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clear_ff;
            wr_data  = 1'b0;
            clear_in = clear_ff + ADDR_W'(1);
            if (clear_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.command == CMD_WRITE) begin
                  wr_en   = in_grid(q_item.src);
                  wr_addr = q_src_addr;
                  wr_data = q_item.opaque;
               end else begin
                  item_in     = q_item;
                  src_addr_in = q_src_addr;
                  dst_addr_in = q_dst_addr;
                  pos_in      = q_item.src;
                  addr_in     = q_src_addr;
                  tgt_in      = q_item.dst;
                  attempt_in  = ATT_DIRECT;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (prev_opaque) begin
               if (give_up) begin
                  result_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  attempt_in = next_attempt;
                  state_in   = ST_PROBE;
               end
            end else if (at_tgt) begin
               result_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               // read this cell now, its opacity is judged next cycle
               rd_addr     = addr_ff;
               pend_in     = 1'b1;
               pend_bad_in = !in_grid(pos_ff);
               pos_in      = step_pos(pos_ff, tgt_ff);
               addr_in     = addr_ff + step_delta(pos_ff, tgt_ff);
            end
         end
         ST_PROBE: begin
            rd_addr = probe_addr;
            if (probe_differ && in_grid(probe_c)) begin
               state_in = ST_PROBE_CHK;
            end else if (give_up) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               attempt_in = next_attempt;
            end
         end
         ST_PROBE_CHK: begin
            if (rd_data) begin
               if (give_up) begin
                  result_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  attempt_in = next_attempt;
                  state_in   = ST_PROBE;
               end
            end else begin
               pos_in   = item_ff.src;
               addr_in  = src_addr_ff;
               tgt_in   = probe_c;
               state_in = ST_WALK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff        <= item_in;
      src_addr_ff    <= src_addr_in;
      dst_addr_ff    <= dst_addr_in;
      pos_ff         <= pos_in;
      tgt_ff         <= tgt_in;
      addr_ff        <= addr_in;
      attempt_ff     <= attempt_in;
      pend_bad_ff    <= pend_bad_in;
      result_ff      <= result_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_visible     = rsp_visible_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.busy     = (state_ff != ST_CLEAR) && (state_ff != ST_IDLE);

endmodule
